/* sv/lcwm_pkg.sv */
`default_nettype none

package lcwm_pkg;

	localparam int WINDOW_DEF = 20;
	localparam int SYMBOLS_DEF = 32;

	localparam int CODE_W = 5;
	localparam int CFG_W = 5;

	localparam logic [CFG_W-1:0] MIN_DISTINCT_RST = 5'd5;

	typedef logic [CODE_W-1:0] code_t;
	typedef logic [CFG_W-1:0] cfg_t;

endpackage

`default_nettype wire

/* sv/lcwm_in_if.sv */
`default_nettype none

interface lcwm_in_if;
	logic valid;
	logic ready;
	lcwm_pkg::code_t residue_code;
	logic is_last;

	modport source (output valid, output residue_code, output is_last, input ready);
	modport sink (input valid, input residue_code, input is_last, output ready);
endinterface

`default_nettype wire

/* sv/lcwm_out_if.sv */
`default_nettype none

interface lcwm_out_if;
	logic valid;
	logic ready;
	logic low_complexity;
	logic last_flag;

	modport source (output valid, output low_complexity, output last_flag, input ready);
	modport sink (input valid, input low_complexity, input last_flag, output ready);
endinterface

`default_nettype wire

/* sv/low_complexity_window_mask_top.sv */
`default_nettype none

// channel   dir  handshake     payload
// in_ch     in   valid/ready   residue_code[4:0], is_last
// out_ch    out  valid/ready   low_complexity, last_flag
// cfg       in   cfg_wr_en     cfg_wr_data[4:0] (min_distinct)
//
// one item accepted per cycle while no sequence is being flushed and the output register is free
// after an item with is_last, one flag per cycle leaves the output register
// while the output is being taken; in_ch.ready stays low until the last one is taken
// outside a flush, in_ch.ready follows the output register: high when it is empty or being taken
// arst_n clears counts, pending flags and sets min_distinct to 5

module low_complexity_window_mask_top #(
	parameter int WINDOW = lcwm_pkg::WINDOW_DEF,
	parameter int SYMBOLS = lcwm_pkg::SYMBOLS_DEF
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic cfg_wr_en,
	input wire lcwm_pkg::cfg_t cfg_wr_data,
	lcwm_in_if.sink in_ch,
	lcwm_out_if.source out_ch
);

	localparam int DEPTH = WINDOW + 6;
	localparam int PC_W = $clog2(DEPTH + 1);
	localparam int CN_W = $clog2(WINDOW + 1);
	localparam int DC_W = $clog2(SYMBOLS + 1);
	localparam int CW = lcwm_pkg::CODE_W;

	localparam logic [PC_W-1:0] DEPTH_P = PC_W'(DEPTH);
	localparam logic [PC_W-1:0] WIN_P = PC_W'(WINDOW);
	localparam logic [CW:0] SYM_X = (CW + 1)'(SYMBOLS);
	localparam lcwm_pkg::code_t SYM_TOP = CW'(SYMBOLS - 1);

	lcwm_pkg::cfg_t min_q;
	lcwm_pkg::code_t codes_q [WINDOW];
	logic [CN_W-1:0] counts_q [SYMBOLS];
	logic [CN_W-1:0] cnt_nx [SYMBOLS];
	logic [DC_W-1:0] dist_q;
	logic [DC_W-1:0] dist_nx;
	logic [PC_W-1:0] rcv_q;
	logic [PC_W-1:0] rcv_nx;
	logic [DEPTH-1:0] pend_q;
	logic [DEPTH-1:0] flags_m;
	logic [PC_W-1:0] pend_cnt_q;
	logic [PC_W-1:0] cnt_a;
	logic [PC_W-1:0] lo;
	logic flush_q;
	logic long_q;
	logic out_valid_q;
	logic lc_q;
	logic lf_q;

	lcwm_pkg::code_t code_c;
	lcwm_pkg::code_t old_c;
	logic drop;
	logic [SYMBOLS-1:0] rise;
	logic [SYMBOLS-1:0] fall;
	logic mark;
	logic out_free;
	logic accept;
	logic emit_item;
	logic emit_flush;

	assign out_free = !out_valid_q || out_ch.ready;
	assign in_ch.ready = !flush_q && out_free;
	assign accept = in_ch.valid && in_ch.ready;

	assign out_ch.valid = out_valid_q;
	assign out_ch.low_complexity = lc_q;
	assign out_ch.last_flag = lf_q;

	// codes beyond the alphabet fold onto the top symbol
	assign code_c = ({1'b0, in_ch.residue_code} >= SYM_X) ? SYM_TOP : in_ch.residue_code;
	assign old_c = codes_q[WINDOW-1];
	assign drop = rcv_q >= WIN_P;

	always_comb begin
		for (int s = 0; s < SYMBOLS; s++) begin
			logic inc;
			logic dec;
			inc = code_c == CW'(s);
			dec = drop && (old_c == CW'(s)) && (counts_q[s] != '0);
			cnt_nx[s] = counts_q[s] + CN_W'(inc) - CN_W'(dec);
			rise[s] = (counts_q[s] == '0) && (cnt_nx[s] != '0);
			fall[s] = (counts_q[s] != '0) && (cnt_nx[s] == '0);
		end
	end

	assign dist_nx = dist_q + DC_W'(|rise) - DC_W'(|fall);
	assign rcv_nx = rcv_q + PC_W'(rcv_q != DEPTH_P);
	assign cnt_a = pend_cnt_q + PC_W'(pend_cnt_q != DEPTH_P);
	assign mark = (rcv_nx >= WIN_P) && (cnt_a >= WIN_P) && (dist_nx < DC_W'(min_q));
	assign lo = cnt_a - WIN_P;

	// mark the positions of the window just completed
	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			if (PC_W'(i) == pend_cnt_q) begin
				flags_m[i] = mark && (PC_W'(i) >= lo);
			end else begin
				flags_m[i] = pend_q[i] | (mark && (PC_W'(i) >= lo) && (PC_W'(i) < cnt_a));
			end
		end
	end

	assign emit_item = accept && !in_ch.is_last && (cnt_a == DEPTH_P);
	assign emit_flush = flush_q && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= lcwm_pkg::MIN_DISTINCT_RST;
			for (int s = 0; s < SYMBOLS; s++) begin
				counts_q[s] <= '0;
			end
			dist_q <= '0;
			rcv_q <= '0;
			pend_q <= '0;
			pend_cnt_q <= '0;
			flush_q <= 1'b0;
			long_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				min_q <= cfg_wr_data;
			end
			if (accept) begin
				if (in_ch.is_last) begin
					for (int s = 0; s < SYMBOLS; s++) begin
						counts_q[s] <= '0;
					end
					dist_q <= '0;
					rcv_q <= '0;
					pend_q <= flags_m;
					pend_cnt_q <= cnt_a;
					flush_q <= 1'b1;
					long_q <= rcv_nx == DEPTH_P;
				end else begin
					for (int s = 0; s < SYMBOLS; s++) begin
						counts_q[s] <= cnt_nx[s];
					end
					dist_q <= dist_nx;
					rcv_q <= rcv_nx;
					if (cnt_a == DEPTH_P) begin
						pend_q <= flags_m >> 1;
						pend_cnt_q <= DEPTH_P - PC_W'(1);
					end else begin
						pend_q <= flags_m;
						pend_cnt_q <= cnt_a;
					end
				end
			end else if (emit_flush) begin
				pend_q <= pend_q >> 1;
				pend_cnt_q <= pend_cnt_q - PC_W'(1);
				if (pend_cnt_q == PC_W'(1)) begin
					flush_q <= 1'b0;
				end
			end
			if (out_free) begin
				out_valid_q <= emit_item || emit_flush;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			codes_q[0] <= code_c;
			for (int i = 1; i < WINDOW; i++) begin
				codes_q[i] <= codes_q[i-1];
			end
		end
		if (emit_item) begin
			lc_q <= flags_m[0];
			lf_q <= 1'b0;
		end else if (emit_flush) begin
			lc_q <= pend_q[0] & long_q;
			lf_q <= pend_cnt_q == PC_W'(1);
		end
	end

endmodule

`default_nettype wire
